// ===== sv/mws_pkg.sv =====
// ----------------------------------------------------------------------------
// mws_pkg
// Shared types and constants for the weighted MDS stress block.
// ----------------------------------------------------------------------------
package mws_pkg;

  localparam int unsigned MAX_DIMS = 4;

  // configuration register indexes
  localparam logic [1:0] CFG_MODE = 2'd0;
  localparam logic [1:0] CFG_DIMS = 2'd1;

  // stress modes (the unused code behaves as raw)
  localparam logic [1:0] MODE_RAW     = 2'd0;
  localparam logic [1:0] MODE_NORM    = 2'd1;
  localparam logic [1:0] MODE_KRUSKAL = 2'd2;
  localparam logic [1:0] MODE_UNUSED  = 2'd3;

  // result status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_ZERO_DEN = 2'd1;
  localparam logic [1:0] ST_SAT      = 2'd2;

  // pair word passed from front to back
  typedef struct packed {
    logic [33:0] d2;
    logic [15:0] diss;
    logic [15:0] weight;
    logic        last;
  } mws_pair_t;

endpackage

// ===== sv/mds_weighted_stress.sv =====
// ----------------------------------------------------------------------------
// mds_weighted_stress
// Weighted raw, normalized or Kruskal stress over a stream of point pairs.
// ----------------------------------------------------------------------------
//  channel | handshake              | payload
//  --------+------------------------+--------------------------------------
//  config  | cfg_we_i               | cfg_idx_i, cfg_data_i
//  pair in | in_valid_i / in_stall_o| point_a/b_0..3, dissimilarity, weight,
//          |                        | last_pair
//  result  | out_valid_o/out_stall_i| stress_value_o, status_o
//
// Front accepts a pair, runs a sum step per dimension lane and pushes it,
// waiting while the queue is full, before taking the next. Back runs the
// 18-step per-pair square root, multiplies and accumulate; a last pair then
// picks the path and, after 96 divider steps in normalized mode or those
// plus the Kruskal square root, loads the result. Reset is asynchronous:
// sums clear, mode is raw and dims is two. The two-entry queue lets the
// front keep taking pairs while the back or the result side is stalled.
// ----------------------------------------------------------------------------
module mds_weighted_stress (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_idx_i,
  input  logic [2:0]         cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic signed [15:0] point_a_0_i,
  input  logic signed [15:0] point_a_1_i,
  input  logic signed [15:0] point_a_2_i,
  input  logic signed [15:0] point_a_3_i,
  input  logic signed [15:0] point_b_0_i,
  input  logic signed [15:0] point_b_1_i,
  input  logic signed [15:0] point_b_2_i,
  input  logic signed [15:0] point_b_3_i,
  input  logic [15:0]        dissimilarity_i,
  input  logic [15:0]        weight_i,
  input  logic               last_pair_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [47:0]        stress_value_o,
  output logic [1:0]         status_o
);
  import mws_pkg::*;

  logic [1:0] mode_q;
  logic [2:0] dims_q;
  logic       push, full, pop, qvalid;
  mws_pair_t  wpair, rpair;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_RAW;
      dims_q <= 3'd2;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == CFG_MODE) begin
        mode_q <= cfg_data_i[1:0];
      end else if (cfg_idx_i == CFG_DIMS) begin
        dims_q <= cfg_data_i;
      end
    end
  end

  mws_front u_front (
    .clk_i, .rst_ni,
    .dims_i (dims_q),
    .in_valid_i, .in_stall_o,
    .point_a_0_i, .point_a_1_i, .point_a_2_i, .point_a_3_i,
    .point_b_0_i, .point_b_1_i, .point_b_2_i, .point_b_3_i,
    .dissimilarity_i, .weight_i, .last_pair_i,
    .push_o (push),
    .pair_o (wpair),
    .full_i (full)
  );

  mws_queue u_queue (
    .clk_i, .rst_ni,
    .push_i  (push),
    .wdata_i (wpair),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (qvalid),
    .rdata_o (rpair)
  );

  mws_back u_back (
    .clk_i, .rst_ni,
    .mode_i  (mode_q),
    .valid_i (qvalid),
    .pair_i  (rpair),
    .pop_o   (pop),
    .out_valid_o, .out_stall_i, .stress_value_o, .status_o
  );

endmodule

// ===== sv/mws_front.sv =====
// ----------------------------------------------------------------------------
// mws_front
// Accepts a pair word and forms the squared distance, one dimension a cycle.
// ----------------------------------------------------------------------------
module mws_front (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic [2:0]              dims_i,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic signed [15:0]      point_a_0_i,
  input  logic signed [15:0]      point_a_1_i,
  input  logic signed [15:0]      point_a_2_i,
  input  logic signed [15:0]      point_a_3_i,
  input  logic signed [15:0]      point_b_0_i,
  input  logic signed [15:0]      point_b_1_i,
  input  logic signed [15:0]      point_b_2_i,
  input  logic signed [15:0]      point_b_3_i,
  input  logic [15:0]             dissimilarity_i,
  input  logic [15:0]             weight_i,
  input  logic                    last_pair_i,
  output logic                    push_o,
  output mws_pkg::mws_pair_t      pair_o,
  input  logic                    full_i
);
  import mws_pkg::*;

  typedef enum logic [1:0] {F_IDLE, F_SUM, F_PUSH} fstate_e;

  fstate_e            state_q;
  logic signed [15:0] a_q [MAX_DIMS];
  logic signed [15:0] b_q [MAX_DIMS];
  logic [1:0]         step_q;
  logic [33:0]        d2_q;
  logic [15:0]        diss_q;
  logic [15:0]        w_q;
  logic               last_q;
  logic [2:0]         eff_dims;
  logic signed [16:0] diff;
  logic [16:0]        mag;
  logic [33:0]        sq;

  assign eff_dims = (dims_i > 3'(MAX_DIMS)) ? 3'(MAX_DIMS) : dims_i;

  // current dimension sits at lane 0
  assign diff = 17'(a_q[0]) - 17'(b_q[0]);
  assign mag  = diff[16] ? 17'(-diff) : 17'(diff);
  assign sq   = mag * mag;

  assign in_stall_o = (state_q != F_IDLE);
  assign push_o     = (state_q == F_PUSH) && !full_i;
  assign pair_o     = '{d2: d2_q, diss: diss_q, weight: w_q, last: last_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
      step_q  <= '0;
      d2_q    <= '0;
      diss_q  <= '0;
      w_q     <= '0;
      last_q  <= 1'b0;
      for (int i = 0; i < MAX_DIMS; i++) begin
        a_q[i] <= '0;
        b_q[i] <= '0;
      end
    end else begin
      case (state_q)
        F_IDLE: begin
          if (in_valid_i) begin
            a_q[0] <= point_a_0_i;
            a_q[1] <= point_a_1_i;
            a_q[2] <= point_a_2_i;
            a_q[3] <= point_a_3_i;
            b_q[0] <= point_b_0_i;
            b_q[1] <= point_b_1_i;
            b_q[2] <= point_b_2_i;
            b_q[3] <= point_b_3_i;
            diss_q  <= dissimilarity_i;
            w_q     <= weight_i;
            last_q  <= last_pair_i;
            d2_q    <= '0;
            step_q  <= '0;
            state_q <= F_SUM;
          end
        end
        F_SUM: begin
          if ({1'b0, step_q} < eff_dims) begin
            d2_q <= d2_q + sq;
          end
          // shift next dimension into lane 0
          for (int i = 0; i < MAX_DIMS - 1; i++) begin
            a_q[i] <= a_q[i+1];
            b_q[i] <= b_q[i+1];
          end
          step_q <= step_q + 2'd1;
          if (step_q == 2'(MAX_DIMS - 1)) begin
            state_q <= F_PUSH;
          end
        end
        F_PUSH: begin
          if (!full_i) begin
            state_q <= F_IDLE;
          end
        end
        default: state_q <= F_IDLE;
      endcase
    end
  end

endmodule

// ===== sv/mws_queue.sv =====
// ----------------------------------------------------------------------------
// mws_queue
// Two-entry queue of pair words between front and back.
// ----------------------------------------------------------------------------
module mws_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  mws_pkg::mws_pair_t wdata_i,
  output logic               full_o,
  input  logic               pop_i,
  output logic               valid_o,
  output mws_pkg::mws_pair_t rdata_o
);
  import mws_pkg::*;

  mws_pair_t  mem_q [2];
  logic       wr_q;
  logic       rd_q;
  logic [1:0] cnt_q;

  assign full_o  = (cnt_q == 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign rdata_o = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q     <= 1'b0;
      rd_q     <= 1'b0;
      cnt_q    <= '0;
      mem_q[0] <= '0;
      mem_q[1] <= '0;
    end else begin
      if (push_i) begin
        mem_q[wr_q] <= wdata_i;
        wr_q        <= ~wr_q;
      end
      if (pop_i) begin
        rd_q <= ~rd_q;
      end
      cnt_q <= cnt_q + 2'(push_i) - 2'(pop_i);
    end
  end

endmodule

// ===== sv/mws_back.sv =====
// ----------------------------------------------------------------------------
// mws_back
// Per-pair square root and weighted sums; on a last pair, a shared restoring
// divider (and a bit-serial square root for Kruskal) forms non-raw stress.
// ----------------------------------------------------------------------------
module mws_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic [1:0]         mode_i,
  input  logic               valid_i,
  input  mws_pkg::mws_pair_t pair_i,
  output logic               pop_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [47:0]        stress_value_o,
  output logic [1:0]         status_o
);
  import mws_pkg::*;

  typedef enum logic [3:0] {
    B_IDLE, B_SQRT, B_MUL1, B_MUL2, B_ACC, B_FIN, B_DIV, B_ROOT, B_DONE
  } bstate_e;

  bstate_e     state_q;
  mws_pair_t   pair_q;
  logic [17:0] d_q;
  logic [17:0] bit_q;
  logic [35:0] rr_q;
  logic [31:0] dd_q;
  logic [51:0] rw_q;
  logic [47:0] tw_q;
  logic [49:0] dw_q;
  logic [63:0] res_sum_q;
  logic [63:0] tgt_sum_q;
  logic [63:0] dst_sum_q;
  logic        sat_q;
  logic [95:0] num_q;
  logic [64:0] rem_q;
  logic [63:0] den_q;
  logic [6:0]  cnt_q;
  logic [47:0] root_q;
  logic [47:0] val_q;
  logic [1:0]  st_q;
  logic        out_valid_q;
  logic [47:0] out_val_q;
  logic [1:0]  out_st_q;

  // per-pair root trial
  logic [17:0] cand;
  logic [35:0] cand_sq;
  assign cand    = d_q | bit_q;
  assign cand_sq = cand * cand;

  // residual magnitude
  logic [17:0] resid;
  assign resid = (d_q >= 18'(pair_q.diss)) ? d_q - 18'(pair_q.diss)
                                           : 18'(pair_q.diss) - d_q;

  // saturating sums
  logic [64:0] res_add, tgt_add, dst_add;
  assign res_add = {1'b0, res_sum_q} + 65'(rw_q);
  assign tgt_add = {1'b0, tgt_sum_q} + 65'(tw_q);
  assign dst_add = {1'b0, dst_sum_q} + 65'(dw_q);

  // divider step
  logic [64:0] div_rem;
  logic        div_ge;
  assign div_rem = {rem_q[63:0], num_q[95]};
  assign div_ge  = (div_rem >= {1'b0, den_q});

  // square root step, two bits of radicand per step
  logic [50:0] sq_rem;
  logic [50:0] sq_trial;
  logic        sq_ge;
  assign sq_rem   = {rem_q[48:0], num_q[95:94]};
  assign sq_trial = 51'({root_q, 2'b01});
  assign sq_ge    = (sq_rem >= sq_trial);

  logic out_free;
  assign out_free = !out_valid_q || !out_stall_i;

  assign pop_o          = (state_q == B_IDLE) && valid_i;
  assign out_valid_o    = out_valid_q;
  assign stress_value_o = out_val_q;
  assign status_o       = out_st_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_IDLE;
      pair_q      <= '0;
      d_q         <= '0;
      bit_q       <= '0;
      rr_q        <= '0;
      dd_q        <= '0;
      rw_q        <= '0;
      tw_q        <= '0;
      dw_q        <= '0;
      res_sum_q   <= '0;
      tgt_sum_q   <= '0;
      dst_sum_q   <= '0;
      sat_q       <= 1'b0;
      num_q       <= '0;
      rem_q       <= '0;
      den_q       <= '0;
      cnt_q       <= '0;
      root_q      <= '0;
      val_q       <= '0;
      st_q        <= ST_OK;
      out_valid_q <= 1'b0;
      out_val_q   <= '0;
      out_st_q    <= ST_OK;
    end else begin
      if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        B_IDLE: begin
          if (valid_i) begin
            pair_q  <= pair_i;
            d_q     <= '0;
            bit_q   <= 18'h20000;
            state_q <= B_SQRT;
          end
        end
        // floor(sqrt(d2)), one bit a cycle
        B_SQRT: begin
          if (36'(cand_sq) <= 36'(pair_q.d2)) begin
            d_q <= cand;
          end
          bit_q <= bit_q >> 1;
          if (bit_q[0]) begin
            state_q <= B_MUL1;
          end
        end
        B_MUL1: begin
          rr_q    <= resid * resid;
          dd_q    <= pair_q.diss * pair_q.diss;
          state_q <= B_MUL2;
        end
        B_MUL2: begin
          rw_q    <= rr_q * pair_q.weight;
          tw_q    <= dd_q * pair_q.weight;
          dw_q    <= pair_q.d2 * pair_q.weight;
          state_q <= B_ACC;
        end
        B_ACC: begin
          res_sum_q <= res_add[64] ? '1 : res_add[63:0];
          tgt_sum_q <= tgt_add[64] ? '1 : tgt_add[63:0];
          dst_sum_q <= dst_add[64] ? '1 : dst_add[63:0];
          if (res_add[64] || tgt_add[64] || dst_add[64]) begin
            sat_q <= 1'b1;
          end
          state_q <= pair_q.last ? B_FIN : B_IDLE;
        end
        // pick the result path
        B_FIN: begin
          rem_q <= '0;
          cnt_q <= '0;
          st_q  <= sat_q ? ST_SAT : ST_OK;
          if (mode_i == MODE_NORM) begin
            if (tgt_sum_q == '0) begin
              val_q   <= '0;
              st_q    <= ST_ZERO_DEN;
              state_q <= B_DONE;
            end else begin
              num_q   <= {16'd0, res_sum_q, 16'd0};
              den_q   <= tgt_sum_q;
              state_q <= B_DIV;
            end
          end else if (mode_i == MODE_KRUSKAL) begin
            if (dst_sum_q == '0) begin
              val_q   <= '0;
              st_q    <= ST_ZERO_DEN;
              state_q <= B_DONE;
            end else begin
              num_q   <= {res_sum_q, 32'd0};
              den_q   <= dst_sum_q;
              state_q <= B_DIV;
            end
          end else begin
            val_q <= res_sum_q[55:8];
            if (res_sum_q[63:56] != '0) begin
              val_q <= '1;
              st_q  <= ST_SAT;
            end
            state_q <= B_DONE;
          end
        end
        // restoring divide, quotient shifts into num_q
        B_DIV: begin
          rem_q <= div_ge ? div_rem - {1'b0, den_q} : div_rem;
          num_q <= {num_q[94:0], div_ge};
          cnt_q <= cnt_q + 7'd1;
          if (cnt_q == 7'd95) begin
            if (mode_i == MODE_KRUSKAL) begin
              state_q <= B_ROOT;
            end else begin
              state_q <= B_DONE;
              val_q   <= {num_q[46:0], div_ge};
              if (num_q[94:47] != '0) begin
                val_q <= '1;
                st_q  <= ST_SAT;
              end
            end
          end
        end
        B_ROOT: begin
          if (cnt_q == 7'd96) begin
            rem_q  <= '0;
            root_q <= '0;
            cnt_q  <= '0;
          end else begin
            rem_q  <= 65'(sq_ge ? sq_rem - sq_trial : sq_rem);
            root_q <= {root_q[46:0], sq_ge};
            num_q  <= {num_q[93:0], 2'b00};
            cnt_q  <= cnt_q + 7'd1;
            if (cnt_q == 7'd47) begin
              val_q   <= {root_q[46:0], sq_ge};
              state_q <= B_DONE;
            end
          end
        end
        B_DONE: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            out_val_q   <= val_q;
            out_st_q    <= st_q;
            res_sum_q   <= '0;
            tgt_sum_q   <= '0;
            dst_sum_q   <= '0;
            sat_q       <= 1'b0;
            state_q     <= B_IDLE;
          end
        end
        default: state_q <= B_IDLE;
      endcase
    end
  end

endmodule

// ===== sv/mws_checker.sv =====
// ----------------------------------------------------------------------------
// mws_checker
// Port-level checks on the stress block, bound to the top level.
// ----------------------------------------------------------------------------
module mws_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [47:0] stress_value_o,
  input logic [1:0]  status_o
);
  import mws_pkg::*;

  // a stalled result word stays
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(stress_value_o))
    else $error("result word dropped under stall");

  // front is busy right after taking a word
  a_front_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("front took a word without going busy");

  // zero denominator reports a zero value
  a_zero_den: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == ST_ZERO_DEN |-> stress_value_o == '0)
    else $error("zero denominator with nonzero value");

  // status is one of the defined codes whenever a result is valid
  a_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> status_o == ST_OK || status_o == ST_ZERO_DEN ||
                    status_o == ST_SAT)
    else $error("undefined status code");

endmodule

bind mds_weighted_stress mws_checker u_mws_checker (.*);

// ===== tb/mds_weighted_stress_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mds_weighted_stress_tb
// Streams point pairs into the stress block through a randomly idling driver
// and checks each stress word against a local model of the weighted sums.
// Covers all modes, directed and random dims, zero denominators, saturation.
// ----------------------------------------------------------------------------
module mds_weighted_stress_tb;
  import mws_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 1000000;
  localparam int unsigned DRAIN_CYCLES = 400;

  typedef struct packed {
    logic [3:0][15:0] pa;
    logic [3:0][15:0] pb;
    logic [15:0]      diss;
    logic [15:0]      wgt;
    logic             last;
  } pair_t;

  typedef struct packed {
    logic [47:0] val;
    logic [1:0]  st;
  } stress_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [1:0] cfg_idx_i = CFG_MODE;
  logic [2:0] cfg_data_i = 3'd0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  pair_t cur = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic [47:0] stress_value_o;
  logic [1:0] status_o;

  pair_t pend_q[$];
  stress_t stress_exp_q[$];
  logic in_acc = 1'b0;
  int unsigned gap_cnt = 0;
  int unsigned stall_cnt = 0;
  logic calm = 1'b0;
  int unsigned err_cnt = 0;
  int unsigned cycle_cnt = 0;

  // model copy of the block's registers and sums
  logic [1:0] mode_q = MODE_RAW;
  logic [2:0] dims_q = 3'd2;
  logic [63:0] res_sum = '0, tgt_sum = '0, dist_sum = '0;
  logic sat_flag = 1'b0;

  mds_weighted_stress dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .in_valid_i, .in_stall_o,
    .point_a_0_i(cur.pa[0]), .point_a_1_i(cur.pa[1]),
    .point_a_2_i(cur.pa[2]), .point_a_3_i(cur.pa[3]),
    .point_b_0_i(cur.pb[0]), .point_b_1_i(cur.pb[1]),
    .point_b_2_i(cur.pb[2]), .point_b_3_i(cur.pb[3]),
    .dissimilarity_i(cur.diss), .weight_i(cur.wgt), .last_pair_i(cur.last),
    .out_valid_o, .out_stall_i, .stress_value_o, .status_o
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // mostly short gaps, a few long, none in calm phases
  function automatic int unsigned pick_gap();
    int unsigned p;
    p = $urandom_range(0, 99);
    if (calm || p < 55) return 0;
    if (p < 90) return $urandom_range(1, 3);
    return $urandom_range(5, 40);
  endfunction

  function automatic logic [63:0] sat_add(logic [63:0] a, logic [63:0] b);
    logic [64:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s[64]) begin
      sat_flag = 1'b1;
      return '1;
    end
    return s[63:0];
  endfunction

  // floor square root, bit by bit from the top
  function automatic logic [47:0] floor_root(logic [95:0] x);
    logic [47:0] r, c;
    logic [95:0] sq;
    r = '0;
    for (int b = 47; b >= 0; b--) begin
      c = r | (48'd1 << b);
      sq = {48'd0, c} * {48'd0, c};
      if (sq <= x) r = c;
    end
    return r;
  endfunction

  // fold one pair into the sums; on a last pair queue the stress word
  function automatic void absorb_pair(pair_t p);
    int unsigned ndims;
    int diff;
    logic [63:0] d2, d, r, diss, w;
    logic [79:0] q80;
    logic [95:0] q96;
    stress_t e;
    ndims = (dims_q > MAX_DIMS) ? MAX_DIMS : dims_q;
    d2 = '0;
    for (int k = 0; k < ndims; k++) begin
      diff = int'($signed(p.pa[k])) - int'($signed(p.pb[k]));
      if (diff < 0) diff = -diff;
      d2 += 64'(diff) * 64'(diff);
    end
    d = 64'(floor_root(96'(d2)));
    diss = 64'(p.diss);
    w = 64'(p.wgt);
    r = (d >= diss) ? d - diss : diss - d;
    res_sum = sat_add(res_sum, r * r * w);
    tgt_sum = sat_add(tgt_sum, diss * diss * w);
    dist_sum = sat_add(dist_sum, d2 * w);
    if (!p.last) return;
    e.st = sat_flag ? ST_SAT : ST_OK;
    if (mode_q == MODE_NORM) begin
      if (tgt_sum == 0) begin
        e.val = '0;
        e.st = ST_ZERO_DEN;
      end else begin
        q80 = {res_sum, 16'd0} / {16'd0, tgt_sum};
        if (q80[79:48] != 0) begin
          e.val = '1;
          e.st = ST_SAT;
        end else begin
          e.val = q80[47:0];
        end
      end
    end else if (mode_q == MODE_KRUSKAL) begin
      if (dist_sum == 0) begin
        e.val = '0;
        e.st = ST_ZERO_DEN;
      end else begin
        q96 = {res_sum, 32'd0} / {32'd0, dist_sum};
        e.val = floor_root(q96);
      end
    end else begin
      if (res_sum[63:56] != 0) begin
        e.val = '1;
        e.st = ST_SAT;
      end else begin
        e.val = res_sum[55:8];
      end
    end
    stress_exp_q.push_back(e);
    res_sum = '0;
    tgt_sum = '0;
    dist_sum = '0;
    sat_flag = 1'b0;
  endfunction

  // pair driver, inputs move on the falling edge
  always @(negedge clk_i) begin
    if (!in_valid_i || in_acc) begin
      if (gap_cnt > 0) begin
        gap_cnt <= gap_cnt - 1;
        in_valid_i <= 1'b0;
      end else if (pend_q.size() > 0) begin
        cur <= pend_q.pop_front();
        in_valid_i <= 1'b1;
        gap_cnt <= pick_gap();
      end else begin
        in_valid_i <= 1'b0;
      end
    end
    // result side back-pressure
    if (stall_cnt > 0) begin
      stall_cnt <= stall_cnt - 1;
      out_stall_i <= 1'b1;
    end else begin
      stall_cnt <= pick_gap();
      out_stall_i <= 1'b0;
    end
  end

  // accept pairs, check stress words, watch the cycle budget
  always @(posedge clk_i) begin
    stress_t e;
    in_acc <= in_valid_i && !in_stall_o;
    if (in_valid_i && !in_stall_o) absorb_pair(cur);
    if (out_valid_o && !out_stall_i) begin
      if (stress_exp_q.size() == 0) begin
        err_cnt++;
        if (err_cnt <= 10)
          $display("unexpected word: value %h status %0d", stress_value_o, status_o);
      end else begin
        e = stress_exp_q.pop_front();
        if (e.val !== stress_value_o || e.st !== status_o) begin
          err_cnt++;
          if (err_cnt <= 10)
            $display("mismatch: value exp %h got %h, status exp %0d got %0d",
                     e.val, stress_value_o, e.st, status_o);
        end
      end
    end
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  function automatic pair_t rand_pair(logic last);
    pair_t p;
    for (int k = 0; k < 4; k++) begin
      p.pa[k] = 16'($urandom);
      p.pb[k] = 16'($urandom);
    end
    // keep many pairs close so residuals stay in range
    if ($urandom_range(0, 2) == 0)
      for (int k = 0; k < 4; k++) p.pb[k] = p.pa[k] + 16'($urandom_range(0, 1023));
    p.diss = 16'($urandom);
    case ($urandom_range(0, 9))
      0: p.wgt = 16'd0;
      1: p.wgt = 16'd256;
      2: p.wgt = 16'hFFFF;
      default: p.wgt = 16'($urandom);
    endcase
    if ($urandom_range(0, 7) == 0) p.diss = 16'd0;
    p.last = last;
    return p;
  endfunction

  function automatic pair_t far_pair(logic [15:0] diss, logic [15:0] wgt, logic last);
    pair_t p;
    p.pa = {4{16'h7FFF}};
    p.pb = {4{16'h8000}};
    p.diss = diss;
    p.wgt = wgt;
    p.last = last;
    return p;
  endfunction

  task automatic wait_idle();
    wait (pend_q.size() == 0 && !in_valid_i && stress_exp_q.size() == 0);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_cfg(logic [1:0] mode, logic [2:0] dims);
    wait_idle();
    cfg_we_i <= 1'b1;
    cfg_idx_i <= CFG_MODE;
    cfg_data_i <= {1'b0, mode};
    mode_q = mode;
    @(negedge clk_i);
    cfg_idx_i <= CFG_DIMS;
    cfg_data_i <= dims;
    dims_q = dims;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // random groups of pairs, each closed by a last pair
  task automatic push_groups(int unsigned n);
    int unsigned len;
    while (n > 0) begin
      len = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 40) : $urandom_range(1, 12);
      if (len > n) len = n;
      for (int unsigned i = 1; i <= len; i++) pend_q.push_back(rand_pair(i == len));
      n -= len;
    end
  endtask

  initial begin
    pair_t p;
    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;
    calm = 1'b0;

    // reset settings: raw mode, two dimensions
    pend_q.push_back(far_pair(16'd0, 16'hFFFF, 1'b1));
    pend_q.push_back(far_pair(16'hFFFF, 16'd0, 1'b1));
    pend_q.push_back(far_pair(16'hFFFF, 16'd256, 1'b0));
    pend_q.push_back(rand_pair(1'b1));

    // normalized: zero target, oversized ratio, plain
    write_cfg(MODE_NORM, 3'd4);
    pend_q.push_back(far_pair(16'd0, 16'd1234, 1'b1));
    pend_q.push_back(far_pair(16'd1, 16'hFFFF, 1'b1));
    pend_q.push_back(rand_pair(1'b0));
    pend_q.push_back(rand_pair(1'b1));

    // Kruskal: coincident points give a zero denominator
    write_cfg(MODE_KRUSKAL, 3'd1);
    p = far_pair(16'd500, 16'd256, 1'b1);
    p.pb = p.pa;
    pend_q.push_back(p);
    pend_q.push_back(far_pair(16'd300, 16'hFFFF, 1'b0));
    pend_q.push_back(rand_pair(1'b1));

    // unused mode acts as raw; no dimensions means zero distance
    write_cfg(MODE_UNUSED, 3'd0);
    pend_q.push_back(far_pair(16'hFFFF, 16'hFFFF, 1'b1));
    pend_q.push_back(rand_pair(1'b1));

    // too many dimensions clamp to four; long burst saturates raw stress
    write_cfg(MODE_RAW, 3'd7);
    for (int i = 1; i <= 70; i++) pend_q.push_back(far_pair(16'd0, 16'hFFFF, i == 70));

    // random phases over all settings
    for (int ph = 0; ph < 12; ph++) begin
      write_cfg(2'($urandom_range(0, 3)), 3'($urandom_range(0, 7)));
      calm = ($urandom_range(0, 3) == 0);
      push_groups(170);
    end

    wait_idle();
    if (err_cnt == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ===== files.f =====
sv/mws_pkg.sv
sv/mws_front.sv
sv/mws_queue.sv
sv/mws_back.sv
sv/mds_weighted_stress.sv
sv/mws_checker.sv
tb/mds_weighted_stress_tb.sv
